// ===== rtl/battery_level_debounce_monitor_unit_macros.svh =====
// Assertion helpers for the battery level monitor. All checks run on clk
// and are disabled while rst_n is low.
`ifndef BATTERY_LEVEL_DEBOUNCE_MONITOR_UNIT_MACROS_SVH
`define BATTERY_LEVEL_DEBOUNCE_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BLDM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("battery level monitor: same-cycle check failed");

// Next-cycle implication.
`define BLDM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("battery level monitor: next-cycle check failed");

`endif

// ===== rtl/bldm_pkg.sv =====
package bldm_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_WARN_ENTER = 3'd0;
  localparam logic [IDX_W-1:0] REG_WARN_EXIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW_ENTER  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOW_EXIT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_EMPTY      = 3'd4;
  localparam logic [IDX_W-1:0] REG_SETTLE     = 3'd5;

  localparam logic [LEVEL_W-1:0] WARN_ENTER_RST = 8'd40;
  localparam logic [LEVEL_W-1:0] WARN_EXIT_RST  = 8'd42;
  localparam logic [LEVEL_W-1:0] LOW_ENTER_RST  = 8'd35;
  localparam logic [LEVEL_W-1:0] LOW_EXIT_RST   = 8'd37;
  localparam logic [LEVEL_W-1:0] EMPTY_RST      = 8'd32;
  localparam logic [COUNT_W-1:0] SETTLE_RST     = 16'd10;
  localparam logic [LEVEL_W-1:0] LOWEST_RST     = 8'hFF;

  // Reported supply status
  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_WARN   = 2'd1;
  localparam logic [1:0] STATUS_LOW    = 2'd2;
  localparam logic [1:0] STATUS_EMPTY  = 2'd3;

  // Reported level state codes
  localparam logic [2:0] CODE_NORMAL = 3'd0;
  localparam logic [2:0] CODE_N2W    = 3'd1;
  localparam logic [2:0] CODE_W2N    = 3'd2;
  localparam logic [2:0] CODE_WARN   = 3'd3;
  localparam logic [2:0] CODE_W2L    = 3'd4;
  localparam logic [2:0] CODE_L2W    = 3'd5;
  localparam logic [2:0] CODE_LOW    = 3'd6;

  typedef enum logic [6:0] {
    ST_NORMAL = 7'b0000001,
    ST_N2W    = 7'b0000010,
    ST_W2N    = 7'b0000100,
    ST_WARN   = 7'b0001000,
    ST_W2L    = 7'b0010000,
    ST_L2W    = 7'b0100000,
    ST_LOW    = 7'b1000000
  } level_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] warn_enter;
    logic [LEVEL_W-1:0] warn_exit;
    logic [LEVEL_W-1:0] low_enter;
    logic [LEVEL_W-1:0] low_exit;
    logic [LEVEL_W-1:0] empty;
    logic [COUNT_W-1:0] settle;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         supply_status;
    logic [2:0]         level_state;
    logic [LEVEL_W-1:0] lowest_voltage;
  } result_t;

  function automatic logic [2:0] level_code(level_t st);
    logic [2:0] code;
    unique case (st)
      ST_NORMAL: code = CODE_NORMAL;
      ST_N2W:    code = CODE_N2W;
      ST_W2N:    code = CODE_W2N;
      ST_WARN:   code = CODE_WARN;
      ST_W2L:    code = CODE_W2L;
      ST_L2W:    code = CODE_L2W;
      ST_LOW:    code = CODE_LOW;
      default:   code = CODE_NORMAL;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/battery_level_debounce_monitor_unit.sv =====
// Battery level monitor, one supply channel. Each voltage beat (tenths of a
// volt) yields exactly one result beat: the supply status (normal, warn, low,
// empty), the seven-state level code after the reading and the lowest reading
// since reset. Level changes pass through a pending state and commit only
// after settle_count further pending readings without crossing back. Output
// valid rises in the cycle after input accept, and a new reading is taken every
// cycle unless out_ready stalls: the comparisons, the counter update and the
// lowest-value compare sit between the level state registers and the output
// register, so the single state update per beat sets the rate at one beat per
// clock. The output register frees as its beat is taken, so input and output
// may both move in the same cycle. Thresholds and the settle count live in an
// APB-style register file (byte address 4 * index, pready always high); the
// user must write them only while no beat is in flight, unchecked by the block.
module battery_level_debounce_monitor_unit
  import bldm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // reading channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LEVEL_W-1:0] in_voltage,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_supply_status,
  output logic [2:0]         out_level_state,
  output logic [LEVEL_W-1:0] out_lowest_voltage
);

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    accept;

  // Take a new beat whenever the output register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign pready   = 1'b1;

  bldm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Level machine, debounce counter and lowest-reading tracker; advance on accept.
  bldm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .voltage (in_voltage),
    .cfg     (cfg),
    .res     (res)
  );

  // Output register: load on accept, drop valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_supply_status  = res_r.supply_status;
  assign out_level_state    = res_r.level_state;
  assign out_lowest_voltage = res_r.lowest_voltage;

endmodule

// ===== rtl/bldm_regs.sv =====
module bldm_regs
  import bldm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t             cfg_r;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn_enter <= WARN_ENTER_RST;
      cfg_r.warn_exit  <= WARN_EXIT_RST;
      cfg_r.low_enter  <= LOW_ENTER_RST;
      cfg_r.low_exit   <= LOW_EXIT_RST;
      cfg_r.empty      <= EMPTY_RST;
      cfg_r.settle     <= SETTLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_WARN_ENTER: cfg_r.warn_enter <= pwdata[LEVEL_W-1:0];
        REG_WARN_EXIT:  cfg_r.warn_exit  <= pwdata[LEVEL_W-1:0];
        REG_LOW_ENTER:  cfg_r.low_enter  <= pwdata[LEVEL_W-1:0];
        REG_LOW_EXIT:   cfg_r.low_exit   <= pwdata[LEVEL_W-1:0];
        REG_EMPTY:      cfg_r.empty      <= pwdata[LEVEL_W-1:0];
        REG_SETTLE:     cfg_r.settle     <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WARN_ENTER: prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_r.warn_enter};
      REG_WARN_EXIT:  prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_r.warn_exit};
      REG_LOW_ENTER:  prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_r.low_enter};
      REG_LOW_EXIT:   prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_r.low_exit};
      REG_EMPTY:      prdata = {{(DATA_W-LEVEL_W){1'b0}}, cfg_r.empty};
      REG_SETTLE:     prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_r.settle};
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/bldm_core.sv =====
`include "battery_level_debounce_monitor_unit_macros.svh"

module bldm_core
  import bldm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [LEVEL_W-1:0] voltage,
  input  cfg_t               cfg,
  output result_t            res
);

  level_t             state_r, state_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEVEL_W-1:0] lowest_r, lowest_nxt;
  logic               pending, back_out;
  level_t             origin, target;
  logic [1:0]         status;
  logic               in_pending;

  always_comb begin
    lowest_nxt = (voltage < lowest_r) ? voltage : lowest_r;
    state_nxt  = state_r;
    pending    = 1'b0;
    back_out   = 1'b0;
    origin     = state_r;
    target     = state_r;

    unique case (state_r)
      ST_NORMAL: begin
        if (voltage < cfg.warn_enter) state_nxt = ST_N2W;
      end
      ST_N2W: begin
        pending  = 1'b1;
        back_out = voltage >= cfg.warn_enter;
        origin   = ST_NORMAL;
        target   = ST_WARN;
      end
      ST_W2N: begin
        pending  = 1'b1;
        back_out = voltage <= cfg.warn_exit;
        origin   = ST_WARN;
        target   = ST_NORMAL;
      end
      ST_WARN: begin
        if (voltage > cfg.warn_exit) begin
          state_nxt = ST_W2N;
        end else if (voltage < cfg.low_enter) begin
          state_nxt = ST_W2L;
        end
      end
      ST_W2L: begin
        pending  = 1'b1;
        back_out = voltage >= cfg.low_enter;
        origin   = ST_WARN;
        target   = ST_LOW;
      end
      ST_L2W: begin
        pending  = 1'b1;
        back_out = voltage <= cfg.low_exit;
        origin   = ST_LOW;
        target   = ST_WARN;
      end
      ST_LOW: begin
        if (voltage > cfg.low_exit) state_nxt = ST_L2W;
      end
      default: ;
    endcase

    // Fall back, keep counting, or commit; clear the counter on any exit.
    cnt_nxt = cnt_r;
    if (pending) begin
      if (back_out) begin
        cnt_nxt   = '0;
        state_nxt = origin;
      end else if (cnt_r < cfg.settle) begin
        cnt_nxt   = cnt_r + 1'b1;
      end else begin
        cnt_nxt   = '0;
        state_nxt = target;
      end
    end
  end

  always_comb begin
    case (state_nxt) inside
      ST_WARN, ST_W2L, ST_W2N: status = STATUS_WARN;
      ST_LOW, ST_L2W:          status = (voltage < cfg.empty) ? STATUS_EMPTY : STATUS_LOW;
      default:                 status = STATUS_NORMAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_NORMAL;
      cnt_r    <= '0;
      lowest_r <= LOWEST_RST;
    end else if (step) begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      lowest_r <= lowest_nxt;
    end
  end

  assign res.supply_status  = status;
  assign res.level_state    = level_code(state_nxt);
  assign res.lowest_voltage = lowest_nxt;

  assign in_pending = (state_r == ST_N2W) || (state_r == ST_W2N) ||
                      (state_r == ST_W2L) || (state_r == ST_L2W);

  `BLDM_ASSERT_IMP(a_count_only_pending, cnt_r != '0, in_pending)
  `BLDM_ASSERT_NXT(a_lowest_monotonic, 1'b1, lowest_r <= $past(lowest_r))
  `BLDM_ASSERT_NXT(a_normal_exit, state_r == ST_NORMAL, state_r == ST_NORMAL || state_r == ST_N2W)

endmodule

// ===== dv/battery_level_debounce_monitor_unit_test.sv =====
module battery_level_debounce_monitor_unit_test;
  import bldm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling: a few hundred readings, each with a random gap and a
  // random result stall, plus nine register settings with readback.
  localparam int RUN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;

  // Unused register slots: writes there must leave every register unchanged.
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [LEVEL_W-1:0] in_voltage = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_supply_status;
  logic [2:0]         out_level_state;
  logic [LEVEL_W-1:0] out_lowest_voltage;

  battery_level_debounce_monitor_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_voltage         (in_voltage),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_supply_status  (out_supply_status),
    .out_level_state    (out_level_state),
    .out_lowest_voltage (out_lowest_voltage)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copy, level code, dwell counter and the
  // lowest reading so far. Updated once per accepted reading beat.
  // ---------------------------------------------------------------------------
  cfg_t               limits;
  logic [2:0]         level_now = CODE_NORMAL;
  logic [COUNT_W-1:0] dwell_cnt = '0;
  logic [LEVEL_W-1:0] floor_v = LOWEST_RST;

  // Readings waiting for the driver, and results owed by the block.
  logic [LEVEL_W-1:0] feed_q[$];
  result_t            status_due[$];

  int          queued_cnt = 0;
  int          accepted_cnt = 0;
  int          beats_checked = 0;
  int          errors = 0;
  int          settings_cnt = 0;
  int          cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  logic        no_idle = 1'b0;
  logic [7:0]  codes_seen = '0;

  // Opening walk with settle count zero and reset thresholds: every back-out,
  // every commit, empty versus low in the low level, both voltage extremes.
  logic [LEVEL_W-1:0] opening_walk[$] = '{
    8'd255, 8'd40, 8'd39, 8'd40, 8'd39, 8'd39, 8'd42, 8'd43,
    8'd42,  8'd43, 8'd43, 8'd39, 8'd0,  8'd35, 8'd34, 8'd35,
    8'd34,  8'd31, 8'd32, 8'd37, 8'd38, 8'd37, 8'd38, 8'd38
  };

  initial begin
    limits = '{warn_enter: WARN_ENTER_RST, warn_exit: WARN_EXIT_RST,
               low_enter: LOW_ENTER_RST, low_exit: LOW_EXIT_RST,
               empty: EMPTY_RST, settle: SETTLE_RST};
  end

  // One pending step: drop back to the origin when the reading crosses back,
  // count while below the settle count, otherwise commit to the target.
  function automatic logic [2:0] dwell_step(input logic fell_back,
                                            input logic [2:0] origin,
                                            input logic [2:0] here,
                                            input logic [2:0] target);
    if (fell_back) begin
      dwell_cnt = '0;
      return origin;
    end
    if (dwell_cnt < limits.settle) begin
      dwell_cnt = dwell_cnt + 1'b1;
      return here;
    end
    dwell_cnt = '0;
    return target;
  endfunction

  // Advance the shadow by one reading and return the result beat it owes.
  function automatic result_t classify_reading(input logic [LEVEL_W-1:0] v);
    result_t    r;
    logic [2:0] nxt;
    if (v < floor_v) floor_v = v;
    nxt = level_now;
    case (level_now)
      CODE_NORMAL: if (v < limits.warn_enter) nxt = CODE_N2W;
      CODE_N2W:    nxt = dwell_step(v >= limits.warn_enter, CODE_NORMAL, CODE_N2W, CODE_WARN);
      CODE_W2N:    nxt = dwell_step(v <= limits.warn_exit, CODE_WARN, CODE_W2N, CODE_NORMAL);
      CODE_WARN: begin
        if (v > limits.warn_exit) nxt = CODE_W2N;
        else if (v < limits.low_enter) nxt = CODE_W2L;
      end
      CODE_W2L:    nxt = dwell_step(v >= limits.low_enter, CODE_WARN, CODE_W2L, CODE_LOW);
      CODE_L2W:    nxt = dwell_step(v <= limits.low_exit, CODE_LOW, CODE_L2W, CODE_WARN);
      CODE_LOW:    if (v > limits.low_exit) nxt = CODE_L2W;
      default: ;
    endcase
    level_now = nxt;
    case (nxt)
      CODE_WARN, CODE_W2L, CODE_W2N: r.supply_status = STATUS_WARN;
      CODE_LOW, CODE_L2W: r.supply_status = (v < limits.empty) ? STATUS_EMPTY : STATUS_LOW;
      default: r.supply_status = STATUS_NORMAL;
    endcase
    r.level_state = nxt;
    r.lowest_voltage = floor_v;
    return r;
  endfunction

  // Mostly land near one of the current thresholds so runs of readings walk
  // the pending states to a commit; sometimes draw anywhere in range.
  function automatic logic [LEVEL_W-1:0] pick_voltage();
    int lvl;
    case ($urandom_range(0, 6))
      0: lvl = int'(limits.warn_enter);
      1: lvl = int'(limits.warn_exit);
      2: lvl = int'(limits.low_enter);
      3: lvl = int'(limits.low_exit);
      4: lvl = int'(limits.empty);
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
    lvl = lvl + int'($urandom_range(0, 4)) - 2;
    if (lvl < 0) lvl = 0;
    if (lvl > 255) lvl = 255;
    return LEVEL_W'(lvl);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle ceiling
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("battery_level_debounce_monitor_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Reading driver: hold a presented beat until taken, then idle for the gap
  // drawn with it, then present the next queued reading.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold valid and payload until the beat is taken
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (feed_q.size() != 0) begin
      in_valid   <= 1'b1;
      in_voltage <= feed_q.pop_front();
      gap_left   <= no_idle ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side back-pressure: after each taken beat, stall for a fresh draw.
  always @(negedge clk) begin : ready_gen
    int unsigned pause;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      pause = out_taken ? (no_idle ? 0 : $urandom_range(0, 4)) : stall_left;
      if (pause != 0) begin
        out_ready  <= 1'b0;
        stall_left <= pause - 1;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge, predict for an accepted reading first, then
  // check a taken result beat against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    result_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      status_due.push_back(classify_reading(in_voltage));
      accepted_cnt++;
    end
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      codes_seen[out_level_state] = 1'b1;
      if (status_due.size() == 0) begin
        $error("result beat with nothing owed: status %0d, level %0d, lowest %0d",
               out_supply_status, out_level_state, out_lowest_voltage);
        errors++;
      end else begin
        want = status_due.pop_front();
        if (out_supply_status !== want.supply_status) begin
          $error("supply_status: expected %0d, got %0d",
                 want.supply_status, out_supply_status);
          errors++;
        end
        if (out_level_state !== want.level_state) begin
          $error("level_state: expected %0d, got %0d", want.level_state, out_level_state);
          errors++;
        end
        if (out_lowest_voltage !== want.lowest_voltage) begin
          $error("lowest_voltage: expected %0d, got %0d",
                 want.lowest_voltage, out_lowest_voltage);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register access: setup then access phase, driven on falling edges.
  // ---------------------------------------------------------------------------
  task automatic reg_read_check(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_WARN_ENTER: want = DATA_W'(limits.warn_enter);
      REG_WARN_EXIT:  want = DATA_W'(limits.warn_exit);
      REG_LOW_ENTER:  want = DATA_W'(limits.low_enter);
      REG_LOW_EXIT:   want = DATA_W'(limits.low_exit);
      REG_EMPTY:      want = DATA_W'(limits.empty);
      default:        want = DATA_W'(limits.settle);
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("register %0d readback: expected %h, got %h", idx, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    for (int i = 0; i <= int'(REG_SETTLE); i++) reg_read_check(IDX_W'(i));
  endtask

  // Write a register with junk above its width, mirror the masked value into
  // the shadow once the access phase lands, and read it back.
  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [COUNT_W-1:0] value);
    logic [DATA_W-1:0] field_mask;
    logic [DATA_W-1:0] word;
    case (idx)
      REG_SETTLE: field_mask = 32'h0000_FFFF;
      REG_WARN_ENTER, REG_WARN_EXIT, REG_LOW_ENTER, REG_LOW_EXIT, REG_EMPTY:
        field_mask = 32'h0000_00FF;
      default: field_mask = '0;
    endcase
    word = (DATA_W'(value) & field_mask) | ($urandom() & ~field_mask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_WARN_ENTER: limits.warn_enter = word[LEVEL_W-1:0];
      REG_WARN_EXIT:  limits.warn_exit  = word[LEVEL_W-1:0];
      REG_LOW_ENTER:  limits.low_enter  = word[LEVEL_W-1:0];
      REG_LOW_EXIT:   limits.low_exit   = word[LEVEL_W-1:0];
      REG_EMPTY:      limits.empty      = word[LEVEL_W-1:0];
      REG_SETTLE:     limits.settle     = word[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (field_mask != '0) reg_read_check(idx);
  endtask

  task automatic set_levels(input int we, input int wx, input int le, input int lx,
                            input int em, input int settle);
    reg_write(REG_WARN_ENTER, COUNT_W'(we));
    reg_write(REG_WARN_EXIT, COUNT_W'(wx));
    reg_write(REG_LOW_ENTER, COUNT_W'(le));
    reg_write(REG_LOW_EXIT, COUNT_W'(lx));
    reg_write(REG_EMPTY, COUNT_W'(em));
    reg_write(REG_SETTLE, COUNT_W'(settle));
    settings_cnt++;
  endtask

  // Ordered thresholds with small hysteresis bands, as a real supply would use.
  task automatic set_sorted_levels(input int settle);
    int em, le, lx, we, wx;
    em = $urandom_range(0, 200);
    le = em + int'($urandom_range(0, 20));
    lx = le + int'($urandom_range(0, 6));
    we = lx + int'($urandom_range(0, 20));
    wx = we + int'($urandom_range(0, 6));
    set_levels(we, wx, le, lx, em, settle);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_reading(input logic [LEVEL_W-1:0] v);
    feed_q.push_back(v);
    queued_cnt++;
  endtask

  // Block until every queued reading is taken and every owed result has come.
  task automatic drain();
    while (accepted_cnt != queued_cnt || status_due.size() != 0) @(negedge clk);
  endtask

  // Runs of one reading up to two past the settle count (capped at twelve), with
  // the odd single stray reading mixed in; then drain.
  task automatic feed_runs(input int n);
    int                 run_len;
    int                 cap;
    logic [LEVEL_W-1:0] v;
    no_idle = ($urandom_range(0, 3) == 0);
    while (n > 0) begin
      v = pick_voltage();
      cap = (limits.settle < 12) ? int'(limits.settle) + 2 : 12;
      run_len = ($urandom_range(0, 5) == 0) ? 1 : int'($urandom_range(1, cap));
      while (run_len > 0 && n > 0) begin
        push_reading(v);
        run_len--;
        n--;
      end
    end
    drain();
  endtask

  // Two chunks per setting, so the sender also sits idle mid-setting until
  // every owed result is in.
  task automatic run_setting(input int n);
    feed_runs(n);
    feed_runs(n);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values first, then the opening walk with immediate commits.
    check_all_regs();
    reg_write(REG_SETTLE, '0);
    foreach (opening_walk[i]) push_reading(opening_walk[i]);
    drain();

    // Lower the settle count under a running dwell: the next pending beat
    // must commit at once.
    reg_write(REG_SETTLE, 16'd5);
    repeat (4) push_reading(8'd43);
    drain();
    reg_write(REG_SETTLE, 16'd1);
    push_reading(8'd43);
    push_reading(8'd40);
    drain();

    // Back to reset thresholds; poke the unused slots and confirm nothing moved.
    set_levels(int'(WARN_ENTER_RST), int'(WARN_EXIT_RST), int'(LOW_ENTER_RST),
               int'(LOW_EXIT_RST), int'(EMPTY_RST), int'(SETTLE_RST));
    reg_write(REG_SPARE_A, '0);
    reg_write(REG_SPARE_B, '1);
    check_all_regs();
    run_setting(40);

    // Extremes: all thresholds at zero, then all at full scale.
    set_levels(0, 0, 0, 0, 0, 0);
    run_setting(25);
    set_levels(255, 255, 255, 255, 255, 0);
    run_setting(25);

    // Settle count at its maximum: pending states never commit.
    set_sorted_levels(65535);
    run_setting(30);

    repeat (4) begin
      set_sorted_levels($urandom_range(0, 6));
      run_setting(30);
    end

    // Unordered thresholds reach corners such as empty while leaving low.
    set_levels($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 3));
    run_setting(25);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d result beats for %0d readings over %0d register settings.",
             beats_checked, accepted_cnt, settings_cnt);
    $display("Level codes reached (bit per code): %b", codes_seen[6:0]);
    if (errors == 0) begin
      $display("battery_level_debounce_monitor_unit: match");
    end else begin
      $display("battery_level_debounce_monitor_unit: mismatch");
    end
    $finish;
  end

endmodule
